// ===== rtl/snt_pkg.sv =====
// Shared types, constants and helper functions for the source nesting tracker.
// No dependencies; every other file in rtl/ uses this package.
package snt_pkg;

    // Stack and column sizing
    localparam int STACK_DEPTH = 32;
    localparam int COL_WIDTH   = 16;
    localparam int SP_WIDTH    = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_WIDTH  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Fixed result field widths
    localparam int DEPTH_WIDTH = 8;
    localparam int PAREN_WIDTH = 6;
    localparam int CONT_WIDTH  = 16;

    typedef logic [COL_WIDTH-1:0]          t_col;
    typedef logic [SP_WIDTH-1:0]           t_sp;
    typedef logic [ADDR_WIDTH-1:0]         t_addr;
    typedef logic signed [DEPTH_WIDTH-1:0] t_depth;

    localparam t_col   COL_MAX   = {COL_WIDTH{1'b1}};
    localparam t_depth DEPTH_MAX = 8'sh7F;
    localparam t_depth DEPTH_MIN = 8'sh80;

    // Characters of interest
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TICK   = 8'h27;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // Fault codes reported with each result
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_DEPTH     = 2'd3
    } t_err;

    // One result request
    typedef struct packed {
        t_depth                  brace_depth;
        logic [PAREN_WIDTH-1:0]  open_parens;
        logic [CONT_WIDTH-1:0]   cont_column;
        logic                    in_string;
        logic                    in_char;
        t_err                    error;
    } t_rsp;

    // Saturating increment of a column count
    function automatic t_col col_inc(input t_col a);
        return (a == COL_MAX) ? a : t_col'(a + t_col'(1));
    endfunction

    // Saturating a + b + 1
    function automatic t_col col_add_inc(input t_col a, input t_col b);
        logic [COL_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b} + (COL_WIDTH+1)'(1);
        return (s > {1'b0, COL_MAX}) ? COL_MAX : s[COL_WIDTH-1:0];
    endfunction

    // Low bits of a column value for the result field
    function automatic logic [CONT_WIDTH-1:0] col_to_cont(input t_col a);
        logic [31:0] t;
        t = 32'(a);
        return t[CONT_WIDTH-1:0];
    endfunction

    // Low bits of the stack pointer for the result field
    function automatic logic [PAREN_WIDTH-1:0] sp_to_parens(input t_sp a);
        logic [15:0] t;
        t = 16'(a);
        return t[PAREN_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/snt_if.sv =====
// Valid/ready channel interfaces for the character and result streams.
// Depends on snt_pkg for field widths.

interface snt_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_in_line;

    modport source (output valid, output ch, output last_in_line, input ready);
    modport sink   (input valid, input ch, input last_in_line, output ready);
endinterface

interface snt_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [snt_pkg::DEPTH_WIDTH-1:0] brace_depth;
    logic [snt_pkg::PAREN_WIDTH-1:0]     open_parens;
    logic [snt_pkg::CONT_WIDTH-1:0]      cont_column;
    logic                                in_string;
    logic                                in_char;
    logic [1:0]                          error;

    modport source (output valid, output brace_depth, output open_parens,
                    output cont_column, output in_string, output in_char,
                    output error, input ready);
    modport sink   (input valid, input brace_depth, input open_parens,
                    input cont_column, input in_string, input in_char,
                    input error, output ready);
endinterface

// ===== rtl/snt_skid.sv =====
// Output register with a skid stage for result requests.
// Depends on snt_pkg for the result struct.
module snt_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  snt_pkg::t_rsp i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output snt_pkg::t_rsp o_data
);

    logic          r_out_valid;
    logic          r_skid_valid;
    snt_pkg::t_rsp r_out;
    snt_pkg::t_rsp r_skid;
    logic          in_fire;

    // Upstream ready is registered: only a full skid stage stalls
    assign o_ready = !r_skid_valid;
    assign in_fire = i_valid && !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= i_data;
            end
        end else if (in_fire) begin
            r_skid <= i_data;
        end
    end

endmodule

// ===== rtl/source_nesting_tracker.sv =====
// Source nesting tracker: quote/escape state, brace depth and paren column stack.
// Results are registered in snt_skid. Throughput: one character per cycle
// unless its skid stage is full; single-pass update, one-write one-read stack.
// Reset (synchronous, active low) clears counters, flags, columns and the stack
// pointer; stack memory contents are not cleared and are only read after a push.
// Depends on snt_pkg, snt_if and snt_skid.
module source_nesting_tracker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    snt_req_if.sink        i_req,
    snt_rsp_if.source      o_rsp
);

    // Tracker state
    snt_pkg::t_depth r_depth,   n_depth;
    snt_pkg::t_sp    r_sp,      n_sp;
    snt_pkg::t_col   r_justify, n_justify;
    snt_pkg::t_col   r_base,    n_base;
    snt_pkg::t_col   r_chars,   n_chars;
    logic            r_quote,   n_quote;
    logic            r_tick,    n_tick;
    logic            r_esc,     n_esc;

    // Column stack: memory plus registered top and next-below entries
    snt_pkg::t_col   r_stack [snt_pkg::STACK_DEPTH];
    snt_pkg::t_col   r_top;
    snt_pkg::t_col   r_below;
    logic            push;
    logic            pop;
    snt_pkg::t_addr  rd_addr;
    snt_pkg::t_sp    rd_sp;

    logic            acc;
    logic            quoted;
    snt_pkg::t_err   err;
    snt_pkg::t_rsp   rsp;
    logic            skid_ready;
    snt_pkg::t_rsp   out_data;

    assign i_req.ready = skid_ready;
    assign acc         = i_req.valid && skid_ready;
    assign quoted      = r_quote || r_tick;

    // Per-character update
    always_comb begin
        n_depth   = r_depth;
        n_sp      = r_sp;
        n_justify = r_justify;
        n_base    = r_base;
        n_chars   = r_chars;
        n_quote   = r_quote;
        n_tick    = r_tick;
        n_esc     = r_esc;
        push      = 1'b0;
        pop       = 1'b0;
        err       = snt_pkg::ERR_NONE;

        if (acc) begin
            case (i_req.ch)
                snt_pkg::CH_BSLASH: begin
                    n_esc   = !r_esc;
                    n_chars = snt_pkg::col_inc(r_chars);
                end
                snt_pkg::CH_TICK: begin
                    n_chars = snt_pkg::col_inc(r_chars);
                    if (!r_esc && !r_quote) begin
                        n_tick = !r_tick;
                    end
                    n_esc = 1'b0;
                end
                snt_pkg::CH_QUOTE: begin
                    n_chars = snt_pkg::col_inc(r_chars);
                    if (!r_esc) begin
                        n_quote = !r_quote;
                    end
                    n_esc = 1'b0;
                end
                snt_pkg::CH_LBRACE, snt_pkg::CH_RBRACE: begin
                    if (!quoted) begin
                        if ((i_req.ch == snt_pkg::CH_LBRACE && r_depth == snt_pkg::DEPTH_MAX) ||
                            (i_req.ch == snt_pkg::CH_RBRACE && r_depth == snt_pkg::DEPTH_MIN))
                        begin
                            err = snt_pkg::ERR_DEPTH;
                        end else begin
                            n_depth = (i_req.ch == snt_pkg::CH_LBRACE) ?
                                      r_depth + 8'sd1 : r_depth - 8'sd1;
                            n_base  = '0;
                            n_chars = '0;
                        end
                    end else begin
                        n_chars = snt_pkg::col_inc(r_chars);
                    end
                    n_esc = 1'b0;
                end
                snt_pkg::CH_LPAREN: begin
                    if (!quoted) begin
                        if (r_sp >= snt_pkg::t_sp'(snt_pkg::STACK_DEPTH)) begin
                            err = snt_pkg::ERR_OVERFLOW;
                        end else begin
                            push    = 1'b1;
                            n_sp    = r_sp + snt_pkg::t_sp'(1);
                            n_base  = snt_pkg::col_add_inc(r_base, r_chars);
                            n_chars = '0;
                        end
                    end else begin
                        n_chars = snt_pkg::col_inc(r_chars);
                    end
                    n_esc = 1'b0;
                end
                snt_pkg::CH_RPAREN: begin
                    if (!quoted) begin
                        if (r_sp == '0) begin
                            err = snt_pkg::ERR_UNDERFLOW;
                        end else begin
                            pop     = 1'b1;
                            n_sp    = r_sp - snt_pkg::t_sp'(1);
                            n_base  = r_top;
                            n_chars = '0;
                        end
                    end else begin
                        n_chars = snt_pkg::col_inc(r_chars);
                    end
                    n_esc = 1'b0;
                end
                default: begin
                    n_chars = snt_pkg::col_inc(r_chars);
                    n_esc   = 1'b0;
                end
            endcase

            // Line end: pick the continuation column
            if (i_req.last_in_line) begin
                n_justify = (n_sp == '0) ? '0 : n_base;
                n_base    = n_justify;
                n_chars   = '0;
                n_esc     = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_sp      <= '0;
            r_justify <= '0;
            r_base    <= '0;
            r_chars   <= '0;
            r_quote   <= 1'b0;
            r_tick    <= 1'b0;
            r_esc     <= 1'b0;
        end else begin
            r_depth   <= n_depth;
            r_sp      <= n_sp;
            r_justify <= n_justify;
            r_base    <= n_base;
            r_chars   <= n_chars;
            r_quote   <= n_quote;
            r_tick    <= n_tick;
            r_esc     <= n_esc;
        end
    end

    // Prefetch the entry below the new top; never the address written this cycle
    assign rd_sp   = n_sp - snt_pkg::t_sp'(2);
    assign rd_addr = rd_sp[snt_pkg::ADDR_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[r_sp[snt_pkg::ADDR_WIDTH-1:0]] <= r_base;
        end
        r_below <= r_stack[rd_addr];
    end

    // Cached top of stack
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_top <= r_base;
        end else if (pop) begin
            r_top <= r_below;
        end
    end

    // Result request, built from the updated state
    always_comb begin
        rsp.brace_depth = n_depth;
        rsp.open_parens = snt_pkg::sp_to_parens(n_sp);
        rsp.cont_column = snt_pkg::col_to_cont(n_justify);
        rsp.in_string   = n_quote;
        rsp.in_char     = n_tick;
        rsp.error       = err;
    end

    snt_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (skid_ready),
        .i_data  (rsp),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_data  (out_data)
    );

    assign o_rsp.brace_depth = out_data.brace_depth;
    assign o_rsp.open_parens = out_data.open_parens;
    assign o_rsp.cont_column = out_data.cont_column;
    assign o_rsp.in_string   = out_data.in_string;
    assign o_rsp.in_char     = out_data.in_char;
    assign o_rsp.error       = out_data.error;

endmodule
